[hw/rtl/bayer_edge_directed_demosaic_unit_defines.svh]
// ----------------------------------------------------------------------------
// Demosaic unit assertion macros
// Shared concurrent-check helpers, clocked on i_clk, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef BAYER_EDGE_DIRECTED_DEMOSAIC_UNIT_DEFINES_SVH
`define BAYER_EDGE_DIRECTED_DEMOSAIC_UNIT_DEFINES_SVH

// check in the same cycle
`define BEDD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check in the next cycle
`define BEDD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bedd_pkg.sv]
// ----------------------------------------------------------------------------
// Demosaic package
// Fixed field widths, register indexes, Bayer site codes and shared structs.
// ----------------------------------------------------------------------------
package bedd_pkg;

    localparam int CFG_BITS    = 12;
    localparam int ROW_BITS    = 12;
    localparam int OUT_BITS    = 8;
    localparam int MIN_SIZE    = 5;
    localparam int WIN_EDGE    = 4;
    localparam int WIN_SIZE    = 5;
    localparam int LINES       = 4;
    localparam int BANK_BITS   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    localparam logic [CFG_BITS-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [CFG_BITS-1:0] RESET_HEIGHT = 12'd480;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_reg_index;

    typedef enum logic [1:0] {
        SITE_RED        = 2'd0,
        SITE_GREEN_RROW = 2'd1,
        SITE_GREEN_BROW = 2'd2,
        SITE_BLUE       = 2'd3
    } t_site;

    typedef struct packed {
        logic  emit;
        t_site site;
        logic  last;
    } t_tag;

    typedef struct packed {
        logic [CFG_BITS-1:0] width;
        logic [CFG_BITS-1:0] height;
    } t_frame_cfg;

    typedef struct packed {
        logic                 empty;
        logic [QCNT_BITS-1:0] count;
    } t_queue_status;

endpackage

[hw/rtl/bedd_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read-first data.
// ----------------------------------------------------------------------------
module bedd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/bedd_front.sv]
// ----------------------------------------------------------------------------
// Demosaic front end
// Tracks raster position, runs the line store and classifies each pixel.
// ----------------------------------------------------------------------------
module bedd_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 8,
    parameter int ENTRY_BITS = $bits(bedd_pkg::t_tag) + bedd_pkg::WIN_SIZE * PIXEL_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [PIXEL_BITS-1:0]    i_raw_pixel,
    input  logic                     i_frame_start,
    input  bedd_pkg::t_frame_cfg     i_cfg,
    input  bedd_pkg::t_queue_status  i_queue,
    output logic                     o_q_push,
    output logic [ENTRY_BITS-1:0]    o_q_entry
);

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int WIDTH_BITS = $clog2(MAX_WIDTH + 1);
    localparam int CMP_BITS   = (WIDTH_BITS > bedd_pkg::CFG_BITS) ? WIDTH_BITS
                                                                  : bedd_pkg::CFG_BITS;
    localparam int RB         = bedd_pkg::ROW_BITS;

    logic                               accept;
    logic [CMP_BITS-1:0]                w_cfg;
    logic [CMP_BITS-1:0]                w_lim;
    logic [RB-1:0]                      h_lim;
    logic [COL_BITS-1:0]                c_start;
    logic [RB-1:0]                      r_start;
    logic [COL_BITS-1:0]                c_cur;
    logic [RB-1:0]                      r_wrap;
    logic [RB-1:0]                      r_cur;
    logic [CMP_BITS-1:0]                c_inc;
    logic [RB-1:0]                      r_inc;
    logic [COL_BITS-1:0]                c_next;
    logic [RB-1:0]                      r_next;
    bedd_pkg::t_tag                     tag;
    logic [bedd_pkg::QCNT_BITS:0]       occupancy;

    logic [COL_BITS-1:0]                r_col, n_col;
    logic [RB-1:0]                      r_row, n_row;
    logic                               r_f1_valid, n_f1_valid;
    logic [PIXEL_BITS-1:0]              r_f1_pixel;
    logic [bedd_pkg::BANK_BITS-1:0]     r_f1_bank;
    bedd_pkg::t_tag                     r_f1_tag;

    logic [bedd_pkg::LINES-1:0][PIXEL_BITS-1:0]    line_rd;
    logic [bedd_pkg::WIN_SIZE-1:0][PIXEL_BITS-1:0] column;

    // Reserve a slot for the item already in the read stage.
    assign occupancy = (bedd_pkg::QCNT_BITS+1)'(i_queue.count)
                     + (bedd_pkg::QCNT_BITS+1)'(r_f1_valid);
    assign o_full    = occupancy >= (bedd_pkg::QCNT_BITS+1)'(bedd_pkg::QUEUE_DEPTH);
    assign accept    = i_push && !o_full;

    always_comb begin
        w_cfg = CMP_BITS'(i_cfg.width);
        if (w_cfg < CMP_BITS'(bedd_pkg::MIN_SIZE)) begin
            w_lim = CMP_BITS'(bedd_pkg::MIN_SIZE);
        end else if (w_cfg > CMP_BITS'(MAX_WIDTH)) begin
            w_lim = CMP_BITS'(MAX_WIDTH);
        end else begin
            w_lim = w_cfg;
        end
        if (i_cfg.height < RB'(bedd_pkg::MIN_SIZE)) begin
            h_lim = RB'(bedd_pkg::MIN_SIZE);
        end else begin
            h_lim = i_cfg.height;
        end

        c_start = i_frame_start ? '0 : r_col;
        r_start = i_frame_start ? '0 : r_row;

        // Fold a position left beyond a shrunk size back into the frame.
        if (CMP_BITS'(c_start) >= w_lim) begin
            c_cur  = '0;
            r_wrap = r_start + RB'(1);
        end else begin
            c_cur  = c_start;
            r_wrap = r_start;
        end
        r_cur = (r_wrap >= h_lim) ? '0 : r_wrap;

        c_inc = CMP_BITS'(c_cur) + CMP_BITS'(1);
        r_inc = r_cur + RB'(1);
        if (c_inc >= w_lim) begin
            c_next = '0;
            r_next = (r_inc >= h_lim) ? '0 : r_inc;
        end else begin
            c_next = c_inc[COL_BITS-1:0];
            r_next = r_cur;
        end

        tag.emit = (r_cur >= RB'(bedd_pkg::WIN_EDGE))
                && (c_cur >= COL_BITS'(bedd_pkg::WIN_EDGE));
        tag.last = (c_next == '0) && (r_next == '0);
        case ({r_cur[0], c_cur[0]})
            2'b00:   tag.site = bedd_pkg::SITE_RED;
            2'b01:   tag.site = bedd_pkg::SITE_GREEN_RROW;
            2'b10:   tag.site = bedd_pkg::SITE_GREEN_BROW;
            default: tag.site = bedd_pkg::SITE_BLUE;
        endcase

        n_col      = accept ? c_next : r_col;
        n_row      = accept ? r_next : r_row;
        n_f1_valid = accept;
    end

    for (genvar k = 0; k < bedd_pkg::LINES; k++) begin : g_line
        bedd_ram #(
            .WIDTH (PIXEL_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_line (
            .i_clk   (i_clk),
            .i_we    (accept && (r_cur[bedd_pkg::BANK_BITS-1:0]
                                 == bedd_pkg::BANK_BITS'(k))),
            .i_waddr (c_cur),
            .i_wdata (i_raw_pixel),
            .i_re    (accept),
            .i_raddr (c_cur),
            .o_rdata (line_rd[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_f1_valid <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_f1_valid <= n_f1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_pixel <= i_raw_pixel;
            r_f1_bank  <= r_cur[bedd_pkg::BANK_BITS-1:0];
            r_f1_tag   <= tag;
        end
    end

    // Rotate banks so that column row 0 is the oldest line.
    always_comb begin
        for (int i = 0; i < bedd_pkg::LINES; i++) begin
            column[i] = line_rd[r_f1_bank + bedd_pkg::BANK_BITS'(i)];
        end
        column[bedd_pkg::WIN_SIZE-1] = r_f1_pixel;
    end

    assign o_q_push  = r_f1_valid;
    assign o_q_entry = {r_f1_tag, column};

endmodule

[hw/rtl/bedd_fifo.sv]
// ----------------------------------------------------------------------------
// Demosaic column queue
// Short register queue between the front end and the window back end.
// ----------------------------------------------------------------------------
`include "bayer_edge_directed_demosaic_unit_defines.svh"

module bedd_fifo #(
    parameter int WIDTH = 43
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic [WIDTH-1:0]        i_data,
    input  logic                    i_pop,
    output logic [WIDTH-1:0]        o_data,
    output bedd_pkg::t_queue_status o_status
);

    localparam int PB = bedd_pkg::QPTR_BITS;
    localparam int CB = bedd_pkg::QCNT_BITS;

    logic [bedd_pkg::QUEUE_DEPTH-1:0][WIDTH-1:0] r_mem;
    logic [PB-1:0] r_wr_ptr, n_wr_ptr;
    logic [PB-1:0] r_rd_ptr, n_rd_ptr;
    logic [CB-1:0] r_count, n_count;

    function automatic logic [PB-1:0] ptr_step(input logic [PB-1:0] p);
        ptr_step = (p == PB'(bedd_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PB'(1);
    endfunction

    always_comb begin
        n_wr_ptr = i_push ? ptr_step(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_step(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count + CB'(i_push) - CB'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

    `BEDD_ASSERT_NOW(a_push_room, i_push, r_count < CB'(bedd_pkg::QUEUE_DEPTH), "queue overrun")
    `BEDD_ASSERT_NOW(a_pop_data, i_pop, r_count != '0, "queue underrun")

endmodule

[hw/rtl/bedd_back.sv]
// ----------------------------------------------------------------------------
// Demosaic back end
// Holds the 5x5 window and interpolates the missing colours.
// ----------------------------------------------------------------------------
`include "bayer_edge_directed_demosaic_unit_defines.svh"

module bedd_back #(
    parameter int PIXEL_BITS = 8,
    parameter int ENTRY_BITS = $bits(bedd_pkg::t_tag) + bedd_pkg::WIN_SIZE * PIXEL_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bedd_pkg::t_queue_status        i_queue,
    input  logic [ENTRY_BITS-1:0]          i_q_entry,
    output logic                           o_q_pop,
    input  logic                           i_pop,
    output logic                           o_empty,
    output logic [bedd_pkg::OUT_BITS-1:0]  o_red,
    output logic [bedd_pkg::OUT_BITS-1:0]  o_green,
    output logic [bedd_pkg::OUT_BITS-1:0]  o_blue,
    output logic                           o_frame_last
);

    localparam int PB = PIXEL_BITS;
    localparam int WS = bedd_pkg::WIN_SIZE;
    localparam int OB = bedd_pkg::OUT_BITS;

    bedd_pkg::t_tag                 q_tag;
    logic [WS-1:0][PB-1:0]          q_column;
    logic [WS-1:0][WS-1:0][PB-1:0]  r_win;

    logic            out_free, s2_free, s2_adv, s1_adv;
    logic            r_s1_valid, n_s1_valid;
    bedd_pkg::t_site r_s1_site;
    logic            r_s1_last;
    logic            r_s2_valid, n_s2_valid;
    logic            r_out_valid, n_out_valid;

    logic [PB-1:0]   dh, dv;
    logic [PB:0]     h_sum, v_sum;
    logic [PB+1:0]   all_sum, diag_sum;

    logic [PB-1:0]   r_s2_centre, r_s2_h_avg, r_s2_v_avg, r_s2_all_avg, r_s2_diag_avg;
    logic            r_s2_lt, r_s2_gt, r_s2_last;
    bedd_pkg::t_site r_s2_site;

    logic [PB-1:0]   green_dir, sel_red, sel_green, sel_blue;
    logic [OB-1:0]   r_out_red, r_out_green, r_out_blue;
    logic            r_out_last;

    function automatic logic [PB-1:0] absdiff(input logic [PB-1:0] a, input logic [PB-1:0] b);
        absdiff = (a > b) ? a - b : b - a;
    endfunction

    assign {q_tag, q_column} = i_q_entry;

    // Ready chain: output register, then arithmetic stage, then window.
    assign out_free = !r_out_valid || i_pop;
    assign s2_free  = !r_s2_valid || out_free;
    assign s2_adv   = r_s2_valid && out_free;
    assign s1_adv   = r_s1_valid && s2_free;
    assign o_q_pop  = !i_queue.empty && (!r_s1_valid || s2_free);

    always_comb begin
        n_s1_valid  = o_q_pop ? q_tag.emit : (s1_adv ? 1'b0 : r_s1_valid);
        n_s2_valid  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : r_s2_valid);
        n_out_valid = s2_adv ? 1'b1 : (i_pop ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Shift the window left and load the new column.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            for (int i = 0; i < WS; i++) begin
                for (int j = 0; j < WS - 1; j++) begin
                    r_win[i][j] <= r_win[i][j+1];
                end
                r_win[i][WS-1] <= q_column[i];
            end
            r_s1_site <= q_tag.site;
            r_s1_last <= q_tag.last;
        end
    end

    always_comb begin
        dh       = absdiff(r_win[2][0], r_win[2][4]);
        dv       = absdiff(r_win[0][2], r_win[4][2]);
        h_sum    = (PB+1)'(r_win[2][1]) + (PB+1)'(r_win[2][3]);
        v_sum    = (PB+1)'(r_win[1][2]) + (PB+1)'(r_win[3][2]);
        all_sum  = (PB+2)'(h_sum) + (PB+2)'(v_sum);
        diag_sum = (PB+2)'(r_win[1][1]) + (PB+2)'(r_win[1][3])
                 + (PB+2)'(r_win[3][1]) + (PB+2)'(r_win[3][3]);
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_centre   <= r_win[2][2];
            r_s2_h_avg    <= h_sum[PB:1];
            r_s2_v_avg    <= v_sum[PB:1];
            r_s2_all_avg  <= all_sum[PB+1:2];
            r_s2_diag_avg <= diag_sum[PB+1:2];
            r_s2_lt       <= dh < dv;
            r_s2_gt       <= dh > dv;
            r_s2_site     <= r_s1_site;
            r_s2_last     <= r_s1_last;
        end
    end

    always_comb begin
        if (r_s2_lt) begin
            green_dir = r_s2_h_avg;
        end else if (r_s2_gt) begin
            green_dir = r_s2_v_avg;
        end else begin
            green_dir = r_s2_all_avg;
        end
        case (r_s2_site)
            bedd_pkg::SITE_RED: begin
                sel_red   = r_s2_centre;
                sel_green = green_dir;
                sel_blue  = r_s2_diag_avg;
            end
            bedd_pkg::SITE_BLUE: begin
                sel_red   = r_s2_diag_avg;
                sel_green = green_dir;
                sel_blue  = r_s2_centre;
            end
            bedd_pkg::SITE_GREEN_RROW: begin
                sel_red   = r_s2_h_avg;
                sel_green = r_s2_centre;
                sel_blue  = r_s2_v_avg;
            end
            default: begin
                sel_red   = r_s2_v_avg;
                sel_green = r_s2_centre;
                sel_blue  = r_s2_h_avg;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out_red   <= sel_red[OB-1:0];
            r_out_green <= sel_green[OB-1:0];
            r_out_blue  <= sel_blue[OB-1:0];
            r_out_last  <= r_s2_last;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_red        = r_out_red;
    assign o_green      = r_out_green;
    assign o_blue       = r_out_blue;
    assign o_frame_last = r_out_last;

    `BEDD_ASSERT_NEXT(a_win_hold, r_s1_valid && !s2_free, $stable(r_win), "window moved under stalled pixel")

endmodule

[hw/rtl/bayer_edge_directed_demosaic_unit.sv]
// ----------------------------------------------------------------------------
// Edge-directed Bayer demosaic unit
// RGGB raw stream in, 8-bit RGB of interior pixels out.
// ----------------------------------------------------------------------------
// Path to the output: front read stage, column queue, window, arithmetic stage, output register.
// Throughput: one pixel per cycle while o_full is low; each pixel reads every bank, writes one.
// Pixels on the outer two rows and columns give no result; the rest give one each.
// Reset: position returns to row 0, column 0; sizes return to 640 x 480.
// Reset does not clear the line store or the window; no clearing pass is needed.
//
// Structure:
//   front : raster position, four line banks and site classification; one
//           pixel enters per cycle while not full; the full column leaves in the next cycle.
//   queue : four-entry column queue, so the front keeps taking pixels while the
//           output waits to be popped, until the queue fills.
//   back  : 5x5 window, gradient compare and averaging, output register.
// The user must write sizes through the configuration port only while the unit is idle; the unit
// leaves this unchecked. Out-of-range sizes are clamped on use (width to 5..MAX_WIDTH, height to >= 5).
module bayer_edge_directed_demosaic_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int PIXEL_BITS = 8
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel input
    input  logic                               i_push,
    output logic                               o_full,
    input  logic [PIXEL_BITS-1:0]              i_raw_pixel,
    input  logic                               i_frame_start,
    // result output
    output logic                               o_empty,
    input  logic                               i_pop,
    output logic [bedd_pkg::OUT_BITS-1:0]      o_red,
    output logic [bedd_pkg::OUT_BITS-1:0]      o_green,
    output logic [bedd_pkg::OUT_BITS-1:0]      o_blue,
    output logic                               o_frame_last,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [0:0]                         i_cfg_idx,
    input  logic [bedd_pkg::CFG_BITS-1:0]      i_cfg_data
);

    localparam int ENTRY_BITS = $bits(bedd_pkg::t_tag) + bedd_pkg::WIN_SIZE * PIXEL_BITS;

    logic [bedd_pkg::CFG_BITS-1:0] r_frame_width, n_frame_width;
    logic [bedd_pkg::CFG_BITS-1:0] r_frame_height, n_frame_height;
    bedd_pkg::t_frame_cfg          frame_cfg;
    bedd_pkg::t_queue_status       q_status;
    logic                          q_push, q_pop;
    logic [ENTRY_BITS-1:0]         q_wdata, q_rdata;

    // Size registers: keep the raw written value, clamp downstream.
    always_comb begin
        n_frame_width  = r_frame_width;
        n_frame_height = r_frame_height;
        if (i_cfg_we) begin
            case (bedd_pkg::t_reg_index'(i_cfg_idx))
                bedd_pkg::REG_FRAME_WIDTH:  n_frame_width  = i_cfg_data;
                bedd_pkg::REG_FRAME_HEIGHT: n_frame_height = i_cfg_data;
                default: begin
                    n_frame_width  = r_frame_width;
                    n_frame_height = r_frame_height;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bedd_pkg::RESET_WIDTH;
            r_frame_height <= bedd_pkg::RESET_HEIGHT;
        end else begin
            r_frame_width  <= n_frame_width;
            r_frame_height <= n_frame_height;
        end
    end

    assign frame_cfg.width  = r_frame_width;
    assign frame_cfg.height = r_frame_height;

    // Front: take pixels, advance the raster position, read the line banks.
    bedd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (i_push),
        .o_full        (o_full),
        .i_raw_pixel   (i_raw_pixel),
        .i_frame_start (i_frame_start),
        .i_cfg         (frame_cfg),
        .i_queue       (q_status),
        .o_q_push      (q_push),
        .o_q_entry     (q_wdata)
    );

    // Queue: decouple the column stream from the output handshake.
    bedd_fifo #(
        .WIDTH (ENTRY_BITS)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_data   (q_wdata),
        .i_pop    (q_pop),
        .o_data   (q_rdata),
        .o_status (q_status)
    );

    // Back: shift the window, interpolate, hold the result until popped.
    bedd_back #(
        .PIXEL_BITS (PIXEL_BITS),
        .ENTRY_BITS (ENTRY_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_queue      (q_status),
        .i_q_entry    (q_rdata),
        .o_q_pop      (q_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue),
        .o_frame_last (o_frame_last)
    );

endmodule
